// ===== rtl/core/sorted_range_count_core_assert.svh =====
// Assertion macros for the sorted range count core.
// Used by the core modules; each expects clk and rst_n in scope.
`ifndef SORTED_RANGE_COUNT_CORE_ASSERT_SVH
`define SORTED_RANGE_COUNT_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define SRCNT_AST_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("srcnt assertion failed");
// next-cycle implication
`define SRCNT_AST_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("srcnt assertion failed");
`else
`define SRCNT_AST_IMP(lbl, ante, cons)
`define SRCNT_AST_NXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/core/srcnt_pkg.sv =====
// Shared types, command codes and microprogram ROM of the sorted range count core.
// No dependencies.
package srcnt_pkg;

    localparam int STEP_W = 4;
    typedef logic [STEP_W-1:0] step_t;

    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;

    localparam step_t S_IDLE   = step_t'(0);
    localparam step_t S_CLR    = step_t'(1);
    localparam step_t S_APP    = step_t'(2);
    localparam step_t S_NOP    = step_t'(3);
    localparam step_t S_QCHK   = step_t'(4);
    localparam step_t S_LOOP   = step_t'(5);
    localparam step_t S_STEP   = step_t'(6);
    localparam step_t S_BOUND  = step_t'(7);
    localparam step_t S_SWITCH = step_t'(8);
    localparam step_t S_FIN    = step_t'(9);
    localparam step_t S_ZERO   = step_t'(10);

    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_LATCH,
        ACT_CLEAR,
        ACT_APPEND,
        ACT_REPORT,
        ACT_QINIT,
        ACT_PROBE,
        ACT_STEP,
        ACT_SWITCH,
        ACT_FINISH,
        ACT_ZERO
    } act_t;

    typedef enum logic [2:0] {
        BR_NEXT,
        BR_ALWAYS,
        BR_DISPATCH,
        BR_QFAIL,
        BR_DONE,
        BR_STRICT
    } br_t;

    typedef struct packed {
        act_t  act;
        logic  emit;
        br_t   br;
        step_t target;
    } uword_t;

    typedef struct packed {
        act_t act;
        logic emit;
    } ctrl_t;

    typedef struct packed {
        logic qfail;   // empty table or inverted range
        logic done;    // search window empty
        logic strict;  // upper-bound pass
    } flags_t;

    function automatic uword_t ucode(input step_t step);
        uword_t w;
        w = '{act: ACT_NONE, emit: 1'b0, br: BR_ALWAYS, target: S_IDLE};
        unique case (step)
            S_IDLE:   w = '{act: ACT_LATCH,  emit: 1'b0, br: BR_DISPATCH, target: S_IDLE};
            S_CLR:    w = '{act: ACT_CLEAR,  emit: 1'b1, br: BR_ALWAYS,   target: S_IDLE};
            S_APP:    w = '{act: ACT_APPEND, emit: 1'b1, br: BR_ALWAYS,   target: S_IDLE};
            S_NOP:    w = '{act: ACT_REPORT, emit: 1'b1, br: BR_ALWAYS,   target: S_IDLE};
            S_QCHK:   w = '{act: ACT_QINIT,  emit: 1'b0, br: BR_QFAIL,    target: S_ZERO};
            S_LOOP:   w = '{act: ACT_PROBE,  emit: 1'b0, br: BR_DONE,     target: S_BOUND};
            S_STEP:   w = '{act: ACT_STEP,   emit: 1'b0, br: BR_ALWAYS,   target: S_LOOP};
            S_BOUND:  w = '{act: ACT_NONE,   emit: 1'b0, br: BR_STRICT,   target: S_FIN};
            S_SWITCH: w = '{act: ACT_SWITCH, emit: 1'b0, br: BR_ALWAYS,   target: S_LOOP};
            S_FIN:    w = '{act: ACT_FINISH, emit: 1'b1, br: BR_ALWAYS,   target: S_IDLE};
            S_ZERO:   w = '{act: ACT_ZERO,   emit: 1'b1, br: BR_ALWAYS,   target: S_IDLE};
            default:  w = '{act: ACT_NONE,   emit: 1'b0, br: BR_ALWAYS,   target: S_IDLE};
        endcase
        return w;
    endfunction

    function automatic step_t dispatch(input logic [1:0] cmd);
        step_t s;
        unique case (cmd)
            CMD_CLEAR:  s = S_CLR;
            CMD_APPEND: s = S_APP;
            CMD_QUERY:  s = S_QCHK;
            default:    s = S_NOP;
        endcase
        return s;
    endfunction

endpackage

// ===== rtl/core/sorted_range_count_core.sv =====
// Top level of the sorted range count core: microcode sequencer plus datapath.
// Depends on srcnt_pkg, srcnt_useq and srcnt_dpath.
//
//   channel   ports                             handshake
//   request   cmd, range_low, range_high        start && !busy
//   result    hit_count, status                 done, one cycle, no back-pressure
//
// Each request runs a microprogram from the accepting edge. Clear, append and
// unused command go straight to their result step. A query on an empty table
// or inverted range gives zero; otherwise it runs a lower-bound and then an
// upper-bound search, each of at most ceil(log2(n+1)) probes, a probe being a
// read through the table memory's registered read port and a window step.
// Reset empties the table; no clearing pass. Busy stays high from accept until
// the result cycle; the next request is taken in that same cycle.
module sorted_range_count_core
#(
    parameter int TABLE_DEPTH = 1024
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [1:0]                           cmd,
    input  logic signed [31:0]                   range_low,
    input  logic signed [31:0]                   range_high,
    output logic                                 done,
    output logic [$clog2(TABLE_DEPTH + 1)-1:0]   hit_count,
    output logic                                 status
);

    srcnt_pkg::ctrl_t  ctrl;
    srcnt_pkg::flags_t flags;

    srcnt_useq u_useq
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .flags (flags),
        .ctrl  (ctrl),
        .busy  (busy)
    );

    srcnt_dpath
    #(
        .TABLE_DEPTH (TABLE_DEPTH)
    )
    u_dpath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .range_low  (range_low),
        .range_high (range_high),
        .flags      (flags),
        .done       (done),
        .hit_count  (hit_count),
        .status     (status)
    );

endmodule

// ===== rtl/core/srcnt_useq.sv =====
// Microcode sequencer: step counter, control ROM lookup and branch logic.
// Depends on srcnt_pkg and sorted_range_count_core_assert.svh.
`include "sorted_range_count_core_assert.svh"

module srcnt_useq
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [1:0]         cmd,
    input  srcnt_pkg::flags_t  flags,
    output srcnt_pkg::ctrl_t   ctrl,
    output logic               busy
);

    srcnt_pkg::step_t  step_reg;
    srcnt_pkg::step_t  step_next;
    srcnt_pkg::uword_t uw;
    srcnt_pkg::step_t  step_inc;

    assign uw       = srcnt_pkg::ucode(step_reg);
    assign step_inc = step_reg + srcnt_pkg::step_t'(1);
    assign ctrl     = '{act: uw.act, emit: uw.emit};
    assign busy     = (step_reg != srcnt_pkg::S_IDLE);

    always_comb
    begin
        unique case (uw.br)
            srcnt_pkg::BR_NEXT:     step_next = step_inc;
            srcnt_pkg::BR_ALWAYS:   step_next = uw.target;
            srcnt_pkg::BR_DISPATCH: step_next = start ? srcnt_pkg::dispatch(cmd) : step_reg;
            srcnt_pkg::BR_QFAIL:    step_next = flags.qfail ? uw.target : step_inc;
            srcnt_pkg::BR_DONE:     step_next = flags.done ? uw.target : step_inc;
            srcnt_pkg::BR_STRICT:   step_next = flags.strict ? uw.target : step_inc;
            default:                step_next = srcnt_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= srcnt_pkg::S_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    // an accepted request always leaves idle
    `SRCNT_AST_NXT(a_accept_busy, start && !busy, busy)
    // result steps always return to idle
    `SRCNT_AST_NXT(a_emit_idle, ctrl.emit, !busy)
    // step counter stays inside the program
    `SRCNT_AST_IMP(a_step_range, 1'b1, step_reg <= srcnt_pkg::S_ZERO)

endmodule

// ===== rtl/core/srcnt_dpath.sv =====
// Datapath: value table memory, entry count, search window and result registers.
// Depends on srcnt_pkg and sorted_range_count_core_assert.svh.
`include "sorted_range_count_core_assert.svh"

module srcnt_dpath
#(
    parameter int TABLE_DEPTH = 1024,
    parameter int IDX_W       = $clog2(TABLE_DEPTH),
    parameter int CNT_W       = $clog2(TABLE_DEPTH + 1)
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  srcnt_pkg::ctrl_t   ctrl,
    input  logic signed [31:0] range_low,
    input  logic signed [31:0] range_high,
    output srcnt_pkg::flags_t  flags,
    output logic               done,
    output logic [CNT_W-1:0]   hit_count,
    output logic               status
);

    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_DEPTH);

    logic [31:0]      mem [TABLE_DEPTH];
    logic [31:0]      rd_reg;
    logic [31:0]      wr_val_reg;
    logic [31:0]      lo_key_reg;
    logic [31:0]      hi_key_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] lo_reg;
    logic [CNT_W-1:0] hi_reg;
    logic [CNT_W-1:0] lb_reg;
    logic [IDX_W-1:0] mid_reg;
    logic             strict_reg;
    logic             done_reg;
    logic [CNT_W-1:0] hit_count_reg;
    logic             status_reg;

    logic [CNT_W-1:0] span;
    logic [CNT_W-1:0] mid_full;
    logic [IDX_W-1:0] mid_idx;
    logic [31:0]      probe_key;
    logic [31:0]      cur_key;
    logic             go_right;
    logic             full;

    assign span      = hi_reg - lo_reg;
    assign mid_full  = lo_reg + (span >> 1);
    assign mid_idx   = mid_full[IDX_W-1:0];
    assign probe_key = {~rd_reg[31], rd_reg[30:0]};
    assign cur_key   = strict_reg ? hi_key_reg : lo_key_reg;
    assign go_right  = strict_reg ? (probe_key <= cur_key) : (probe_key < cur_key);
    assign full      = (count_reg == FULL_CNT);

    assign flags.qfail  = (count_reg == '0) || (lo_key_reg > hi_key_reg);
    assign flags.done   = (lo_reg >= hi_reg);
    assign flags.strict = strict_reg;

    assign done      = done_reg;
    assign hit_count = hit_count_reg;
    assign status    = status_reg;

    // table memory: one write port at the fill point, one registered read at mid
    always_ff @(posedge clk)
    begin
        if (ctrl.act == srcnt_pkg::ACT_APPEND && !full)
        begin
            mem[count_reg[IDX_W-1:0]] <= wr_val_reg;
        end
        if (ctrl.act == srcnt_pkg::ACT_PROBE)
        begin
            rd_reg <= mem[mid_idx];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        unique case (ctrl.act)
            srcnt_pkg::ACT_LATCH:
            begin
                wr_val_reg <= range_low;
                lo_key_reg <= {~range_low[31], range_low[30:0]};
                hi_key_reg <= {~range_high[31], range_high[30:0]};
            end
            srcnt_pkg::ACT_QINIT:
            begin
                lo_reg <= '0;
                hi_reg <= count_reg;
            end
            srcnt_pkg::ACT_PROBE:
            begin
                mid_reg <= mid_idx;
            end
            srcnt_pkg::ACT_STEP:
            begin
                if (go_right)
                begin
                    lo_reg <= CNT_W'(mid_reg) + CNT_W'(1);
                end
                else
                begin
                    hi_reg <= CNT_W'(mid_reg);
                end
            end
            srcnt_pkg::ACT_SWITCH:
            begin
                lb_reg <= lo_reg;
                lo_reg <= '0;
                hi_reg <= count_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            strict_reg    <= 1'b0;
            done_reg      <= 1'b0;
            hit_count_reg <= '0;
            status_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= ctrl.emit;
            unique case (ctrl.act)
                srcnt_pkg::ACT_CLEAR:
                begin
                    count_reg     <= '0;
                    hit_count_reg <= '0;
                    status_reg    <= 1'b0;
                end
                srcnt_pkg::ACT_APPEND:
                begin
                    if (full)
                    begin
                        hit_count_reg <= count_reg;
                        status_reg    <= 1'b1;
                    end
                    else
                    begin
                        count_reg     <= count_reg + CNT_W'(1);
                        hit_count_reg <= count_reg + CNT_W'(1);
                        status_reg    <= 1'b0;
                    end
                end
                srcnt_pkg::ACT_REPORT:
                begin
                    hit_count_reg <= count_reg;
                    status_reg    <= 1'b0;
                end
                srcnt_pkg::ACT_QINIT:
                begin
                    strict_reg <= 1'b0;
                end
                srcnt_pkg::ACT_SWITCH:
                begin
                    strict_reg <= 1'b1;
                end
                srcnt_pkg::ACT_FINISH:
                begin
                    // lo now holds the upper bound; unsorted data can put it below lb
                    hit_count_reg <= (lo_reg > lb_reg) ? (lo_reg - lb_reg) : '0;
                    status_reg    <= 1'b0;
                end
                srcnt_pkg::ACT_ZERO:
                begin
                    hit_count_reg <= '0;
                    status_reg    <= 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    `SRCNT_AST_IMP(a_count_max, 1'b1, count_reg <= FULL_CNT)
    `SRCNT_AST_IMP(a_window, ctrl.act == srcnt_pkg::ACT_STEP, lo_reg < hi_reg)
    `SRCNT_AST_NXT(a_strobe_pulse, done_reg, !done_reg)
    `SRCNT_AST_IMP(a_drop_full, done_reg && status_reg, hit_count_reg == FULL_CNT)

endmodule

// ===== verif/srcnt_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the sorted range count core: watches requests and results,
// keeps its own copy of the table and compares every result. Needs srcnt_pkg.
module srcnt_checker
#(
    parameter int DEPTH = 1024
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic                            busy,
    input  logic [1:0]                      cmd,
    input  logic signed [31:0]              range_low,
    input  logic signed [31:0]              range_high,
    input  logic                            done,
    input  logic [$clog2(DEPTH + 1)-1:0]    hit_count,
    input  logic                            status,
    output int                              fail_count,
    output int                              pending
);

    localparam int CW = $clog2(DEPTH + 1);

    typedef struct packed {
        logic [CW-1:0] count;
        logic          dropped;
    } reply_t;

    logic signed [31:0] held [DEPTH];
    int                 held_n = 0;
    reply_t             reply_due [$];
    int                 fails = 0;
    int                 due_n = 0;

    assign fail_count = fails;
    assign pending    = due_n;

    // First index whose value is >= key, or > key on the upper-bound pass.
    // Same midpoint as the hardware, so unsorted tables give a fixed answer.
    function automatic int bound_index(input logic signed [31:0] key, input bit strict);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = held_n;
        while (lo < hi)
        begin
            mid = lo + (hi - lo) / 2;
            if (strict ? (held[mid] <= key) : (held[mid] < key))
                lo = mid + 1;
            else
                hi = mid;
        end
        return lo;
    endfunction

    function automatic reply_t table_response(input logic [1:0] op,
                                              input logic signed [31:0] lo_end,
                                              input logic signed [31:0] hi_end);
        reply_t r;
        int     lb;
        int     ub;
        r.count   = CW'(held_n);
        r.dropped = 1'b0;
        case (op)
            srcnt_pkg::CMD_CLEAR:
            begin
                held_n  = 0;
                r.count = '0;
            end
            srcnt_pkg::CMD_APPEND:
            begin
                if (held_n < DEPTH)
                begin
                    held[held_n] = lo_end;
                    held_n++;
                end
                else
                    r.dropped = 1'b1;
                r.count = CW'(held_n);
            end
            srcnt_pkg::CMD_QUERY:
            begin
                if (held_n == 0 || lo_end > hi_end)
                    r.count = '0;
                else
                begin
                    lb = bound_index(lo_end, 1'b0);
                    ub = bound_index(hi_end, 1'b1);
                    r.count = (ub > lb) ? CW'(ub - lb) : '0;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge clk)
    begin
        reply_t want;
        reply_t fresh;
        if (rst_n)
        begin
            if (done)
            begin
                if (reply_due.size() == 0)
                begin
                    $display("%0t: result with no request waiting: hit_count=%0d status=%0b",
                             $time, hit_count, status);
                    fails++;
                end
                else
                begin
                    want = reply_due.pop_front();
                    if (hit_count !== want.count)
                    begin
                        $display("%0t: hit_count mismatch: expected %0d, actual %0d",
                                 $time, want.count, hit_count);
                        fails++;
                    end
                    if (status !== want.dropped)
                    begin
                        $display("%0t: status mismatch: expected %0b, actual %0b",
                                 $time, want.dropped, status);
                        fails++;
                    end
                end
            end
            // a request can be taken in the same cycle as the previous result
            if (start && !busy)
            begin
                fresh     = table_response(cmd, range_low, range_high);
                reply_due = {reply_due, fresh};
            end
            due_n = reply_due.size();
        end
    end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench top for the sorted range count core: clock, reset, request stimulus
// and final verdict. Needs srcnt_pkg, sorted_range_count_core and srcnt_checker.
module tb_top;

    localparam int                 DEPTH      = 1024;
    localparam int                 CW         = $clog2(DEPTH + 1);
    localparam logic [1:0]         CMD_UNUSED = 2'd3;
    localparam logic signed [31:0] VMIN       = 32'sh8000_0000;
    localparam logic signed [31:0] VMAX       = 32'sh7fff_ffff;
    localparam int                 N_ITEMS    = 1250;
    // the closing full-table phase sends a little over DEPTH requests
    localparam int                 N_RANDOM   = N_ITEMS - DEPTH - 64;

    logic                 clk        = 1'b0;
    logic                 rst_n      = 1'b0;
    logic                 start      = 1'b0;
    logic [1:0]           cmd        = srcnt_pkg::CMD_CLEAR;
    logic signed [31:0]   range_low  = '0;
    logic signed [31:0]   range_high = '0;
    logic                 busy;
    logic                 done;
    logic [CW-1:0]        hit_count;
    logic                 status;
    int                   fail_count;
    int                   pending;

    // values the table should hold, used only to aim query ends
    logic signed [31:0]   loaded [$];
    int                   sent       = 0;
    int                   burst_left = 0;

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    sorted_range_count_core #(.TABLE_DEPTH(DEPTH)) dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .cmd        (cmd),
        .range_low  (range_low),
        .range_high (range_high),
        .done       (done),
        .hit_count  (hit_count),
        .status     (status)
    );

    srcnt_checker #(.DEPTH(DEPTH)) u_checker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .cmd        (cmd),
        .range_low  (range_low),
        .range_high (range_high),
        .done       (done),
        .hit_count  (hit_count),
        .status     (status),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Called at a rising edge; returns at the taking edge or after an idle gap.
    task automatic issue(input logic [1:0] c, input logic signed [31:0] a,
                         input logic signed [31:0] b);
        start      <= 1'b1;
        cmd        <= c;
        range_low  <= a;
        range_high <= b;
        do
            @(posedge clk);
        while (busy);
        sent++;
        if (c == srcnt_pkg::CMD_CLEAR)
            loaded.delete();
        else if (c == srcnt_pkg::CMD_APPEND && loaded.size() < DEPTH)
            loaded = {loaded, a};
        if (burst_left == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = $urandom_range(1, 40);
        end
        else
            burst_left--;
    endtask

    // hold off until every request has its result
    task automatic wait_idle();
        start <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        @(posedge clk);
    endtask

    function automatic logic signed [31:0] pick_end();
        logic signed [31:0] s;
        s = (loaded.size() != 0) ? loaded[$urandom_range(0, loaded.size() - 1)] : $urandom();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return s;
            4:          return s + 1;
            5:          return s - 1;
            6:          return VMIN;
            7:          return VMAX;
            default:    return $urandom();
        endcase
    endfunction

    task automatic query_some(input int n, input bit ordered);
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] t;
        repeat (n)
        begin
            a = pick_end();
            b = pick_end();
            if (ordered && a > b)
            begin
                t = a;
                a = b;
                b = t;
            end
            issue(srcnt_pkg::CMD_QUERY, a, b);
        end
    endtask

    // ascending run of appends; step 0 gives duplicates, saturates at the top
    task automatic load_ascending(input int n, input longint first, input int stepmax);
        longint v;
        v = first;
        repeat (n)
        begin
            issue(srcnt_pkg::CMD_APPEND, v[31:0], $urandom());
            v += $urandom_range(0, stepmax);
            if (v > longint'(VMAX))
                v = longint'(VMAX);
        end
    endtask

    function automatic int pick_step();
        case ($urandom_range(0, 3))
            0:       return $urandom_range(0, 3);
            1:       return 1000;
            2:       return 1 << 20;
            default: return 1 << 26;
        endcase
    endfunction

    initial
    begin
        int     r;
        int     n;
        longint first;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, extremes, inverted and empty ranges
        issue(srcnt_pkg::CMD_QUERY, VMIN, VMAX);
        issue(CMD_UNUSED, 32'sd5, 32'sd6);
        issue(srcnt_pkg::CMD_APPEND, VMIN, '0);
        issue(srcnt_pkg::CMD_APPEND, -32'sd1, '0);
        issue(srcnt_pkg::CMD_APPEND, 32'sd0, '0);
        issue(srcnt_pkg::CMD_APPEND, 32'sd1, '0);
        issue(srcnt_pkg::CMD_APPEND, VMAX, '0);
        issue(srcnt_pkg::CMD_APPEND, VMAX, '0);
        issue(srcnt_pkg::CMD_QUERY, VMIN, VMAX);
        issue(srcnt_pkg::CMD_QUERY, 32'sd1, 32'sd0);
        issue(srcnt_pkg::CMD_QUERY, 32'sd0, 32'sd0);
        issue(srcnt_pkg::CMD_QUERY, VMAX, VMAX);
        issue(srcnt_pkg::CMD_QUERY, VMIN, VMIN);
        issue(srcnt_pkg::CMD_QUERY, -32'sd1, 32'sd1);
        issue(srcnt_pkg::CMD_QUERY, 32'sd2, VMAX - 1);
        issue(srcnt_pkg::CMD_QUERY, VMIN + 1, -32'sd2);
        issue(CMD_UNUSED, VMAX, VMIN);
        // out-of-order value: search answer is still fixed
        issue(srcnt_pkg::CMD_APPEND, -32'sd7, '0);
        issue(srcnt_pkg::CMD_QUERY, -32'sd7, -32'sd7);
        issue(srcnt_pkg::CMD_QUERY, VMIN, 32'sd0);
        issue(srcnt_pkg::CMD_CLEAR, VMAX, VMIN);
        issue(srcnt_pkg::CMD_QUERY, VMIN, VMAX);
        wait_idle();

        while (sent < N_RANDOM)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
            begin
                if ($urandom_range(0, 1))
                    issue(srcnt_pkg::CMD_CLEAR, $urandom(), $urandom());
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 300)
                                                : $urandom_range(1, 40);
                first = longint'($signed(32'($urandom())));
                load_ascending(n, first, pick_step());
                query_some($urandom_range(2, 12), $urandom_range(0, 4) != 0);
            end
            else if (r < 80)
            begin
                repeat ($urandom_range(1, 4))
                    issue(srcnt_pkg::CMD_APPEND, $urandom(), $urandom());
                query_some($urandom_range(1, 4), 1'b1);
            end
            else if (r < 88)
                query_some($urandom_range(1, 6), 1'b0);
            else if (r < 94)
                issue($urandom_range(0, 1) ? CMD_UNUSED : srcnt_pkg::CMD_CLEAR,
                      $urandom(), $urandom());
            else
                wait_idle();
        end

        // fill to the last entry, then overflow it
        wait_idle();
        issue(srcnt_pkg::CMD_CLEAR, '0, '0);
        load_ascending(DEPTH, longint'(VMIN) + $urandom_range(0, 1 << 20), 1 << 22);
        repeat (3) issue(srcnt_pkg::CMD_APPEND, $urandom(), $urandom());
        issue(srcnt_pkg::CMD_QUERY, VMIN, VMAX);
        issue(CMD_UNUSED, '0, '0);
        query_some(20, 1'b1);
        query_some(5, 1'b0);
        issue(srcnt_pkg::CMD_CLEAR, '0, '0);
        issue(srcnt_pkg::CMD_QUERY, VMIN, VMAX);

        wait_idle();
        repeat (64) @(posedge clk);
        @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
